FILE: src/bdq_pkg.sv
// Shared types, constants and codes for the bounded linked-list deque.
package bdq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VAL_W      = 32;
    localparam int COUNT_W    = 5;

    localparam logic [2:0] CMD_PUSH_FRONT    = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK     = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT     = 3'd2;
    localparam logic [2:0] CMD_POP_BACK      = 3'd3;
    localparam logic [2:0] CMD_INSERT_SORTED = 3'd4;
    localparam logic [2:0] CMD_REMOVE_VALUE  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]              cmd;
        logic signed [VAL_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [1:0]              status;
        logic [COUNT_W-1:0]      count;
    } rsp_item_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] data;
    } val_wr_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } lnk_wr_t;

    typedef struct packed {
        logic             take;
        logic             give;
        logic [IDX_W-1:0] slot;
    } alloc_ctl_t;

endpackage

FILE: src/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/bdq_alloc.sv
// Free-slot map with lowest-free-slot selection.
module bdq_alloc
    import bdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alloc_ctl_t       ctl,
    output logic [IDX_W-1:0] free_slot
);

    logic [CAPACITY-1:0] free_map_reg;
    logic [CAPACITY-1:0] free_map_next;

    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_map_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        free_map_next = free_map_reg;
        if (ctl.take)
        begin
            free_map_next[free_slot] = 1'b0;
        end
        if (ctl.give)
        begin
            free_map_next[ctl.slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg <= '1;
        end
        else
        begin
            free_map_reg <= free_map_next;
        end
    end

endmodule

FILE: src/bdq_ctrl.sv
// Command sequencer: list walk, link updates, head/tail/count and result register.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_item_t             rsp,
    output alloc_ctl_t            alloc,
    input  logic [IDX_W-1:0]      free_slot,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic [DATA_WIDTH-1:0] val_rd,
    input  logic [IDX_W-1:0]      nxt_rd,
    input  logic [IDX_W-1:0]      prv_rd,
    output val_wr_t               val_wr,
    output lnk_wr_t               nxt_wr,
    output lnk_wr_t               prv_wr
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_LINK, S_DONE} state_t;

    state_t                       state_reg, state_next;
    logic [2:0]                   cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0]        value_reg, value_next;
    logic [IDX_W-1:0]             cur_reg, cur_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [IDX_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic signed [DATA_WIDTH-1:0] res_reg, res_next;
    logic [1:0]                   status_reg, status_next;
    logic                         tail_seen_reg, tail_seen_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    rsp_item_t                    rsp_reg, rsp_next;

    logic                  empty;
    logic                  full;
    logic                  multi;
    logic [DATA_WIDTH-1:0] din;
    logic                  at_tail;
    logic                  ge;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign multi     = (count_reg > CNT_W'(1));
    assign din       = DATA_WIDTH'(req.value);
    assign at_tail   = (cur_reg == tail_reg);
    assign ge        = ($signed(val_rd) >= $signed(value_reg));
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        tail_seen_next = tail_seen_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rd_addr        = cur_reg;
        alloc          = '{take: 1'b0, give: 1'b0, slot: cur_reg};
        val_wr         = '{we: 1'b0, addr: free_slot, data: value_reg};
        nxt_wr         = '{we: 1'b0, addr: free_slot, data: head_reg};
        prv_wr         = '{we: 1'b0, addr: head_reg, data: free_slot};

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = (req.cmd == CMD_POP_BACK) ? tail_reg : head_reg;
                if (req_valid)
                begin
                    cmd_next       = req.cmd;
                    value_next     = din;
                    cur_next       = rd_addr;
                    res_next       = '0;
                    status_next    = ST_OK;
                    tail_seen_next = 1'b0;
                    state_next     = S_DONE;
                    if (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK ||
                        req.cmd == CMD_INSERT_SORTED)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (req.cmd == CMD_INSERT_SORTED && !empty)
                        begin
                            state_next = S_WALK;
                        end
                        else
                        begin
                            alloc.take  = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            val_wr.we   = 1'b1;
                            val_wr.data = din;
                            if (empty)
                            begin
                                head_next = free_slot;
                                tail_next = free_slot;
                            end
                            else if (req.cmd == CMD_PUSH_FRONT)
                            begin
                                nxt_wr.we = 1'b1;
                                prv_wr.we = 1'b1;
                                head_next = free_slot;
                            end
                            else
                            begin
                                prv_wr    = '{we: 1'b1, addr: free_slot, data: tail_reg};
                                nxt_wr    = '{we: 1'b1, addr: tail_reg, data: free_slot};
                                tail_next = free_slot;
                            end
                        end
                    end
                    else if (req.cmd == CMD_POP_FRONT || req.cmd == CMD_POP_BACK ||
                             req.cmd == CMD_REMOVE_VALUE)
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_WALK:
            begin
                if (cmd_reg == CMD_INSERT_SORTED)
                begin
                    if (ge || at_tail)
                    begin
                        alloc.take = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        val_wr.we  = 1'b1;
                        state_next = S_DONE;
                        if (ge && cur_reg == head_reg)
                        begin
                            nxt_wr.we = 1'b1;
                            prv_wr.we = 1'b1;
                            head_next = free_slot;
                        end
                        else if (ge)
                        begin
                            nxt_wr     = '{we: 1'b1, addr: prv_rd, data: free_slot};
                            prv_wr     = '{we: 1'b1, addr: free_slot, data: prv_rd};
                            slot_next  = free_slot;
                            state_next = S_LINK;
                        end
                        else
                        begin
                            prv_wr    = '{we: 1'b1, addr: free_slot, data: tail_reg};
                            nxt_wr    = '{we: 1'b1, addr: tail_reg, data: free_slot};
                            tail_next = free_slot;
                        end
                    end
                    else
                    begin
                        rd_addr  = nxt_rd;
                        cur_next = nxt_rd;
                    end
                end
                else if (cmd_reg == CMD_REMOVE_VALUE && val_rd != value_reg)
                begin
                    // head first, then tail, then the middle from the head
                    if (at_tail && (!tail_seen_reg || slot_reg == tail_reg))
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else if (at_tail)
                    begin
                        rd_addr  = slot_reg;
                        cur_next = slot_reg;
                    end
                    else if (!tail_seen_reg)
                    begin
                        tail_seen_next = 1'b1;
                        slot_next      = nxt_rd;
                        rd_addr        = tail_reg;
                        cur_next       = tail_reg;
                    end
                    else if (nxt_rd == tail_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_addr  = nxt_rd;
                        cur_next = nxt_rd;
                    end
                end
                else
                begin
                    // unlink the current entry
                    res_next   = $signed(val_rd);
                    alloc.give = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                    if (multi)
                    begin
                        if (cur_reg == head_reg)
                        begin
                            head_next = nxt_rd;
                        end
                        else if (at_tail)
                        begin
                            tail_next = prv_rd;
                        end
                        else
                        begin
                            nxt_wr = '{we: 1'b1, addr: prv_rd, data: nxt_rd};
                            prv_wr = '{we: 1'b1, addr: nxt_rd, data: prv_rd};
                        end
                    end
                end
            end

            S_LINK:
            begin
                nxt_wr     = '{we: 1'b1, addr: slot_reg, data: cur_reg};
                prv_wr     = '{we: 1'b1, addr: cur_reg, data: slot_reg};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.result_value = VAL_W'(res_reg);
                    rsp_next.status       = status_reg;
                    rsp_next.count        = COUNT_W'(count_reg);
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            value_reg     <= '0;
            cur_reg       <= '0;
            slot_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            res_reg       <= '0;
            status_reg    <= ST_OK;
            tail_seen_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            value_reg     <= value_next;
            cur_reg       <= cur_next;
            slot_reg      <= slot_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            res_reg       <= res_next;
            status_reg    <= status_next;
            tail_seen_reg <= tail_seen_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

FILE: src/bounded_deque_sorted_list_top.sv
// Top level of the bounded linked-list deque with sorted insert and remove by value.
//
// Request channel (req_valid/req_ready/req) takes one command: push front, push back,
// pop front, pop back, sorted insert or remove by value. Response channel
// (rsp_valid/rsp_ready/rsp) returns one item per request: value, status, new count.
// Entries live in three RAMs (values, next links, prev links) with registered reads;
// a free map, head, tail and count sit in flops.
// Pushes, spare codes and commands that fail at once go from idle straight to the
// response state; pops pass once through the walk state; sorted insert and remove
// by value compare one entry per walk step, plus a second link write for a middle insert.
// Remove compares the head, then the tail, then walks the middle from the head.
// Worst case: a remove on a full list, or an insert into 15 entries before the tail.
// Only one request is in flight; the next request is taken the cycle after the
// response is loaded into the output register.
// A stalled response waits in the output register while the next request is already
// accepted and processed; its result is held until the register frees up.
// Reset (rst_n low, async) empties the list; RAM contents need no clearing and the
// block takes requests in the first cycle after reset.
module bounded_deque_sorted_list_top
    import bdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    alloc_ctl_t            alloc;
    logic [IDX_W-1:0]      free_slot;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] val_rd;
    logic [IDX_W-1:0]      nxt_rd;
    logic [IDX_W-1:0]      prv_rd;
    val_wr_t               val_wr;
    lnk_wr_t               nxt_wr;
    lnk_wr_t               prv_wr;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .alloc     (alloc),
        .free_slot (free_slot),
        .rd_addr   (rd_addr),
        .val_rd    (val_rd),
        .nxt_rd    (nxt_rd),
        .prv_rd    (prv_rd),
        .val_wr    (val_wr),
        .nxt_wr    (nxt_wr),
        .prv_wr    (prv_wr)
    );

    bdq_alloc u_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (alloc),
        .free_slot (free_slot)
    );

    bdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_wr.we),
        .waddr (val_wr.addr),
        .wdata (val_wr.data),
        .raddr (rd_addr),
        .rdata (val_rd)
    );

    bdq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_wr.we),
        .waddr (nxt_wr.addr),
        .wdata (nxt_wr.data),
        .raddr (rd_addr),
        .rdata (nxt_rd)
    );

    bdq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prv_ram (
        .clk   (clk),
        .we    (prv_wr.we),
        .waddr (prv_wr.addr),
        .wdata (prv_wr.data),
        .raddr (rd_addr),
        .rdata (prv_rd)
    );

endmodule

FILE: src/bdq_checker.sv
// Port-level checker for the deque top level, attached by bind.
module bdq_checker
    import bdq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one is in flight");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.result_value == '0)
        else $error("empty status with entries or value");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |->
            rsp.count == COUNT_W'(CAPACITY) && rsp.result_value == '0)
        else $error("full status below capacity or with value");

endmodule

bind bounded_deque_sorted_list_top bdq_checker u_bdq_checker (.*);
